// ===== design/vtp_pkg.sv =====
// Shared constants, types and helpers for the vertex transform block.
package vtp_pkg;

   localparam int FRAC_BITS_DEF     = 16;
   localparam int NEAR_ZERO_EPS_DEF = 66;
   localparam int NUM_REGS          = 8;
   localparam int REG_W             = 64;
   localparam int IDX_W             = $clog2(NUM_REGS);
   localparam int FIX_W             = 32;
   localparam int DIV_STEPS         = 4;

   typedef logic signed [FIX_W-1:0] fix_type;

   typedef struct packed {
      logic                       cmd;
      logic                       skip;
      logic [2:0]                 neg;
      logic [2:0][FIX_W-1:0]      raw;
      logic [FIX_W-1:0]           den;
   } side_type;

   function automatic fix_type sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
         sat32 = fix_type'(hi);
      end else if (v < lo) begin
         sat32 = fix_type'(lo);
      end else begin
         sat32 = v[FIX_W-1:0];
      end
   endfunction

endpackage

// ===== design/vtp_req_if.sv =====
// Input channel: one vertex beat with its mode bit.
interface vtp_req_if;
   logic                valid;
   logic                ready;
   logic                cmd;
   logic signed [31:0]  vec_x;
   logic signed [31:0]  vec_y;
   logic signed [31:0]  vec_z;
   logic signed [31:0]  w_in;

   modport source (output valid, cmd, vec_x, vec_y, vec_z, w_in, input ready);
   modport sink   (input valid, cmd, vec_x, vec_y, vec_z, w_in, output ready);
endinterface

// ===== design/vtp_rsp_if.sv =====
// Result channel: one transformed vertex beat.
interface vtp_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  out_x;
   logic signed [31:0]  out_y;
   logic signed [31:0]  out_z;
   logic                divide_skipped;

   modport source (output valid, out_x, out_y, out_z, divide_skipped, input ready);
   modport sink   (input valid, out_x, out_y, out_z, divide_skipped, output ready);
endinterface

// ===== design/vtp_mac.sv =====
// Two-stage multiply and column-sum array for the 4x4 matrix product.
module vtp_mac #(
   parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic [3:0][vtp_pkg::FIX_W-1:0]         vec,
   input  logic [3:0][3:0][vtp_pkg::FIX_W-1:0]    mat,
   output logic [3:0][vtp_pkg::FIX_W-1:0]         col_ff
);
   import vtp_pkg::*;

   logic signed [63:0]        prod_ff [4][4];
   logic signed [63:0]        prod_in [4][4];
   logic [3:0][FIX_W-1:0]     col_in;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            prod_in[r][c] = 64'($signed(vec[r])) * 64'($signed(mat[r][c]));
         end
      end
   end

   always_comb begin
      logic signed [33:0] sum;
      logic signed [63:0] sh;
      for (int c = 0; c < 4; c++) begin
         sum = '0;
         for (int r = 0; r < 4; r++) begin
            sh  = prod_ff[r][c] >>> FRAC_BITS;
            sum = sum + 34'(sat32(sh));
         end
         col_in[c] = sat32(64'(sum));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         col_ff  <= col_in;
      end
   end

endmodule

// ===== design/vtp_div_stage.sv =====
// One stage of the restoring divider: a few quotient bits per beat.
module vtp_div_stage #(
   parameter int ACC_W = 48
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [vtp_pkg::FIX_W-1:0]  den,
   input  logic [vtp_pkg::FIX_W:0]    rem_i,
   input  logic [ACC_W-1:0]           acc_i,
   output logic [vtp_pkg::FIX_W:0]    rem_ff,
   output logic [ACC_W-1:0]           acc_ff
);
   import vtp_pkg::*;

   logic [FIX_W:0]   rem_in;
   logic [ACC_W-1:0] acc_in;

   always_comb begin
      rem_in = rem_i;
      acc_in = acc_i;
      for (int s = 0; s < DIV_STEPS; s++) begin
         rem_in = {rem_in[FIX_W-1:0], acc_in[ACC_W-1]};
         acc_in = {acc_in[ACC_W-2:0], 1'b0};
         if (rem_in >= {1'b0, den}) begin
            rem_in    = rem_in - {1'b0, den};
            acc_in[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== design/vertex_transform_persp_divide.sv =====
// Top level: 4x4 vertex transform with optional perspective divide.
// Accepts one vertex per cycle unless the pipe holds; its stages are multiply,
// column sum, divisor prep, a radix-16 divider pipeline and the output
// register. The whole pipe holds while the output register is full and not taken.
// Matrix registers reset to identity and should be written only while idle.
module vertex_transform_persp_divide #(
   parameter int FRAC_BITS     = vtp_pkg::FRAC_BITS_DEF,
   parameter int NEAR_ZERO_EPS = vtp_pkg::NEAR_ZERO_EPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   vtp_req_if.sink                       req,
   vtp_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [vtp_pkg::IDX_W-1:0]     csr_index,
   input  logic [vtp_pkg::REG_W-1:0]     csr_wdata
);
   import vtp_pkg::*;

   localparam int NUM_W      = FIX_W + FRAC_BITS;
   localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int ACC_W      = DIV_STAGES * DIV_STEPS;
   localparam int NV         = DIV_STAGES + 4;
   localparam logic [REG_W-1:0] ONE_LO = REG_W'(64'd1 << FRAC_BITS);
   localparam logic [REG_W-1:0] ONE_HI = REG_W'(64'd1 << (FRAC_BITS + 32));

   logic [REG_W-1:0]          mat_ff [NUM_REGS];
   logic [NV-1:0]             vld_ff;
   logic                      en;
   logic [3:0][FIX_W-1:0]     vec;
   logic [3:0][3:0][FIX_W-1:0] mat;
   logic [3:0][FIX_W-1:0]     col_ff;
   logic                      cmd_a_ff;
   logic                      cmd_b_ff;
   side_type                  side_ff [DIV_STAGES+1];
   side_type                  side_in;
   logic [ACC_W-1:0]          acc_c_ff [3];
   logic [ACC_W-1:0]          acc_c_in [3];
   logic [FIX_W:0]            rem_w [DIV_STAGES+1][3];
   logic [ACC_W-1:0]          acc_w [DIV_STAGES+1][3];
   logic [2:0][FIX_W-1:0]     res_ff;
   logic [2:0][FIX_W-1:0]     res_in;
   logic                      skip_ff;
   logic                      skip_in;

   assign en        = !vld_ff[NV-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff[0] <= ONE_LO;
         mat_ff[1] <= '0;
         mat_ff[2] <= ONE_HI;
         mat_ff[3] <= '0;
         mat_ff[4] <= '0;
         mat_ff[5] <= ONE_LO;
         mat_ff[6] <= '0;
         mat_ff[7] <= ONE_HI;
      end else if (csr_we) begin
         mat_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            mat[r][c] = mat_ff[r*2 + c/2][32*(c%2) +: 32];
         end
      end
   end

   assign vec = {req.w_in, req.vec_z, req.vec_y, req.vec_x};

   vtp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock  (clock),
      .en     (en),
      .vec    (vec),
      .mat    (mat),
      .col_ff (col_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NV-2:0], req.valid};
      end
   end

   always_comb begin
      logic [FIX_W:0] mag3;
      logic [FIX_W:0] magj;
      mag3 = col_ff[3][FIX_W-1] ? -{1'b1, col_ff[3]} : {1'b0, col_ff[3]};
      side_in.cmd  = cmd_b_ff;
      side_in.skip = (col_ff[3] == '0) || (mag3 < (FIX_W+1)'(NEAR_ZERO_EPS));
      side_in.den  = mag3[FIX_W-1:0];
      for (int j = 0; j < 3; j++) begin
         magj = col_ff[j][FIX_W-1] ? -{1'b1, col_ff[j]} : {1'b0, col_ff[j]};
         side_in.neg[j] = col_ff[j][FIX_W-1] ^ col_ff[3][FIX_W-1];
         side_in.raw[j] = col_ff[j];
         acc_c_in[j]    = ACC_W'(magj[FIX_W-1:0]) << FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmd_a_ff   <= req.cmd;
         cmd_b_ff   <= cmd_a_ff;
         side_ff[0] <= side_in;
         acc_c_ff   <= acc_c_in;
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         rem_w[0][j] = '0;
         acc_w[0][j] = acc_c_ff[j];
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      for (genvar j = 0; j < 3; j++) begin : g_lane
         vtp_div_stage #(.ACC_W(ACC_W)) u_stage (
            .clock  (clock),
            .en     (en),
            .den    (side_ff[k].den),
            .rem_i  (rem_w[k][j]),
            .acc_i  (acc_w[k][j]),
            .rem_ff (rem_w[k+1][j]),
            .acc_ff (acc_w[k+1][j])
         );
      end
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   always_comb begin
      logic [ACC_W-1:0] q;
      side_type         sd;
      sd      = side_ff[DIV_STAGES];
      skip_in = sd.cmd && sd.skip;
      for (int j = 0; j < 3; j++) begin
         q = acc_w[DIV_STAGES][j];
         if (!sd.cmd || sd.skip) begin
            res_in[j] = sd.raw[j];
         end else if (sd.neg[j]) begin
            res_in[j] = (q > ACC_W'(33'h0_8000_0000)) ? 32'h8000_0000 : -q[FIX_W-1:0];
         end else begin
            res_in[j] = (q > ACC_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : q[FIX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff  <= res_in;
         skip_ff <= skip_in;
      end
   end

   assign rsp.valid          = vld_ff[NV-1];
   assign rsp.out_x          = res_ff[0];
   assign rsp.out_y          = res_ff[1];
   assign rsp.out_z          = res_ff[2];
   assign rsp.divide_skipped = skip_ff;

endmodule

// ===== test/tb_vertex_transform_persp_divide.sv =====
// Testbench for vertex_transform_persp_divide: directed and random vertices checked against a predictor.
`timescale 1ns / 1ps

module tb_vertex_transform_persp_divide;
   import vtp_pkg::*;

   localparam longint Q_MAX     = 64'sd2147483647;
   localparam longint Q_MIN     = -64'sd2147483648;
   localparam int     FRAC      = FRAC_BITS_DEF;
   localparam longint EPS       = NEAR_ZERO_EPS_DEF;
   localparam int     SETTLE    = 40;
   localparam int     CYCLE_CAP = 500000;
   localparam logic   CMD_AFFINE = 1'b0;
   localparam logic   CMD_PERSP  = 1'b1;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        skip;
   } vertex_out_type;

   typedef struct {
      logic        cmd;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] w;
      bit          typed;
      logic [31:0] ex;
      logic [31:0] ey;
      logic [31:0] ez;
      logic        eskip;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [REG_W-1:0] csr_wdata;

   vtp_req_if req_ch();
   vtp_rsp_if rsp_ch();

   vertex_transform_persp_divide uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [REG_W-1:0] matrix_regs [NUM_REGS];
   vertex_out_type   pending_vertices[$];
   int               fail_count = 0;
   int               src_gap_max = 7;
   int               snk_stall_max = 7;
   int               cycle_count = 0;
   dir_row_type      dir_rows[14];

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic longint clamp_q(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   function automatic longint matrix_entry(int r, int c);
      logic [63:0] rv;
      logic [31:0] half;
      rv = matrix_regs[r*2 + c/2];
      half = (c % 2) ? rv[63:32] : rv[31:0];
      return longint'($signed(half));
   endfunction

   function automatic longint column_sum(longint v[4], int c);
      longint s;
      longint p;
      s = 0;
      for (int r = 0; r < 4; r++) begin
         p = v[r] * matrix_entry(r, c);
         s += clamp_q(p >>> FRAC);
      end
      return clamp_q(s);
   endfunction

   function automatic longint scale_by_w(longint num, longint den);
      bit neg;
      longint unsigned un;
      longint unsigned ud;
      longint unsigned q;
      neg = (num < 0) != (den < 0);
      un = longint'(num < 0 ? -num : num) << FRAC;
      ud = longint'(den < 0 ? -den : den);
      q = un / ud;
      if (neg) return (q > 64'h8000_0000) ? Q_MIN : -longint'(q);
      return (q > 64'h7FFF_FFFF) ? Q_MAX : longint'(q);
   endfunction

   function automatic vertex_out_type transform_vertex(logic cmd, logic [31:0] x,
                                                       logic [31:0] y, logic [31:0] z,
                                                       logic [31:0] w);
      longint v[4];
      longint c[3];
      longint wt;
      longint mag;
      vertex_out_type o;
      v[0] = longint'($signed(x));
      v[1] = longint'($signed(y));
      v[2] = longint'($signed(z));
      v[3] = longint'($signed(w));
      for (int j = 0; j < 3; j++) c[j] = column_sum(v, j);
      o.skip = 1'b0;
      if (cmd == CMD_PERSP) begin
         wt = column_sum(v, 3);
         mag = wt < 0 ? -wt : wt;
         if (wt == 0 || mag < EPS) begin
            o.skip = 1'b1;
         end else begin
            for (int j = 0; j < 3; j++) c[j] = scale_by_w(c[j], wt);
         end
      end
      o.x = c[0][31:0];
      o.y = c[1][31:0];
      o.z = c[2][31:0];
      return o;
   endfunction

   task automatic send_vertex(logic cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] w, bit typed, vertex_out_type typed_out);
      int gap;
      gap = $urandom_range(0, src_gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= cmd;
      req_ch.vec_x <= x;
      req_ch.vec_y <= y;
      req_ch.vec_z <= z;
      req_ch.w_in  <= w;
      do @(posedge clock); while (!req_ch.ready);
      pending_vertices.push_back(typed ? typed_out : transform_vertex(cmd, x, y, z, w));
   endtask

   task automatic drain_pipe();
      req_ch.valid <= 1'b0;
      wait (pending_vertices.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic load_matrix(logic [REG_W-1:0] vals [NUM_REGS]);
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= IDX_W'(i);
         csr_wdata <= vals[i];
         matrix_regs[i] = vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'($signed($urandom_range(0, 400)) - 200);
         4: return 32'h0001_0000;
         default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      endcase
   endfunction

   function automatic logic [31:0] pick_entry(int style);
      case (style)
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return $urandom;
         default: return ($urandom_range(0, 3) == 0) ? $urandom
                         : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      endcase
   endfunction

   // result side
   initial begin
      int stall;
      vertex_out_type exp_v;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = $urandom_range(0, snk_stall_max);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (pending_vertices.size() == 0) begin
            $display("%0t: unexpected beat x=%h y=%h z=%h skip=%b", $time, rsp_ch.out_x,
                     rsp_ch.out_y, rsp_ch.out_z, rsp_ch.divide_skipped);
            fail_count++;
         end else begin
            exp_v = pending_vertices.pop_front();
            if (rsp_ch.out_x !== exp_v.x) begin
               $display("%0t: out_x expected %h actual %h", $time, exp_v.x, rsp_ch.out_x);
               fail_count++;
            end
            if (rsp_ch.out_y !== exp_v.y) begin
               $display("%0t: out_y expected %h actual %h", $time, exp_v.y, rsp_ch.out_y);
               fail_count++;
            end
            if (rsp_ch.out_z !== exp_v.z) begin
               $display("%0t: out_z expected %h actual %h", $time, exp_v.z, rsp_ch.out_z);
               fail_count++;
            end
            if (rsp_ch.divide_skipped !== exp_v.skip) begin
               $display("%0t: divide_skipped expected %b actual %b", $time, exp_v.skip,
                        rsp_ch.divide_skipped);
               fail_count++;
            end
         end
      end
   end

   initial begin
      vertex_out_type t;
      logic [REG_W-1:0] m [NUM_REGS];
      int style;
      logic [31:0] a;
      logic [31:0] b;
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      req_ch.valid <= 1'b0;
      req_ch.cmd   <= CMD_AFFINE;
      req_ch.vec_x <= '0;
      req_ch.vec_y <= '0;
      req_ch.vec_z <= '0;
      req_ch.w_in  <= '0;
      matrix_regs[0] = 64'h0000_0000_0001_0000;
      matrix_regs[1] = 64'h0;
      matrix_regs[2] = 64'h0001_0000_0000_0000;
      matrix_regs[3] = 64'h0;
      matrix_regs[4] = 64'h0;
      matrix_regs[5] = 64'h0000_0000_0001_0000;
      matrix_regs[6] = 64'h0;
      matrix_regs[7] = 64'h0001_0000_0000_0000;

      dir_rows = '{
         '{CMD_AFFINE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000,
           1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0},
         '{CMD_AFFINE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
           1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0},
         '{CMD_AFFINE, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
           1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b0},
         '{CMD_PERSP, 32'h0005_0000, 32'hFFFB_0000, 32'h7FFF_FFFF, 32'h0,
           1, 32'h0005_0000, 32'hFFFB_0000, 32'h7FFF_FFFF, 1'b1},
         '{CMD_PERSP, 32'h0001_2345, 32'h0, 32'h8000_0000, 32'd65,
           1, 32'h0001_2345, 32'h0, 32'h8000_0000, 1'b1},
         '{CMD_PERSP, 32'h0001_2345, 32'h0, 32'h0000_0100, 32'hFFFF_FFBF,
           1, 32'h0001_2345, 32'h0, 32'h0000_0100, 1'b1},
         '{CMD_PERSP, 32'h0000_0042, 32'h1234_5678, 32'hFFFF_FF00, 32'd66,
           0, 0, 0, 0, 0},
         '{CMD_PERSP, 32'h0000_0042, 32'h0, 32'hFFFF_FF00, 32'hFFFF_FFBE,
           0, 0, 0, 0, 0},
         '{CMD_PERSP, 32'h0003_0000, 32'hFFFE_0000, 32'h0, 32'h0001_0000,
           1, 32'h0003_0000, 32'hFFFE_0000, 32'h0, 1'b0},
         '{CMD_PERSP, 32'h0002_0000, 32'hFFFD_0000, 32'h0, 32'hFFFF_0000,
           1, 32'hFFFE_0000, 32'h0003_0000, 32'h0, 1'b0},
         '{CMD_PERSP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0000_8000,
           1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000, 1'b0},
         '{CMD_PERSP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000,
           0, 0, 0, 0, 0},
         '{CMD_PERSP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF,
           0, 0, 0, 0, 0},
         '{CMD_AFFINE, 32'h0, 32'h0, 32'h0, 32'h0,
           1, 32'h0, 32'h0, 32'h0, 1'b0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         t.x = dir_rows[i].ex;
         t.y = dir_rows[i].ey;
         t.z = dir_rows[i].ez;
         t.skip = dir_rows[i].eskip;
         send_vertex(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                     dir_rows[i].w, dir_rows[i].typed, t);
      end
      drain_pipe();

      for (int phase = 0; phase < 10; phase++) begin
         style = (phase < 4) ? phase : 4;
         for (int i = 0; i < NUM_REGS; i++) begin
            a = pick_entry(style);
            b = pick_entry(style);
            m[i] = {b, a};
         end
         load_matrix(m);
         src_gap_max   = (phase % 3 == 1) ? 0 : 7;
         snk_stall_max = (phase % 3 == 2) ? 0 : 7;
         for (int n = 0; n < 124; n++) begin
            a = ($urandom_range(0, 2) == 0) ? pick_coord()
                : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            send_vertex($urandom_range(0, 3) != 0 ? CMD_PERSP : CMD_AFFINE,
                        pick_coord(), pick_coord(), pick_coord(), a, 0, t);
         end
         drain_pipe();
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
